// ===== hw/rtl/ezq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ezq_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int OUT_BITS   = 16;

    // Q30 fixed point working widths
    typedef logic [29:0]        xq_t;    // |half angle| in Q30, at most 0.5
    typedef logic [28:0]        usq_t;   // xq squared, at most 0.25
    typedef logic [32:0]        coef_t;  // Horner partial sums and coefficients
    typedef logic signed [32:0] q30_t;   // signed sine, cosine and products
    typedef logic signed [34:0] qsum_t;  // sum of two products

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [OUT_BITS-1:0]   qout_t;

    typedef struct packed {
        angle_t yaw_angle;
        angle_t pitch_angle;
        angle_t roll_angle;
    } angles_t;

    typedef struct packed {
        qout_t quat_w;
        qout_t quat_x;
        qout_t quat_y;
        qout_t quat_z;
    } quat_t;

    localparam coef_t Q30_ONE = 33'd1073741824;

    // sin(pi x): pi^11/11! down to pi, Q30
    localparam coef_t SIN_COEF [0:5] = '{
        33'd7913939, 33'd88203478, 33'd643455390,
        33'd2738217788, 33'd5548789346, 33'd3373259426
    };

    // cos(pi x): pi^12/12! down to pi^2/2!, Q30
    localparam coef_t COS_COEF [0:5] = '{
        33'd2071860, 33'd27709937, 33'd252684340,
        33'd1433727482, 33'd4358008966, 33'd5298703515
    };

    // Output scaling: round the Q30 magnitude half up, or shift left for wide outputs
    localparam int RND_SH = (OUT_BITS < 31) ? 31 - OUT_BITS : 0;
    localparam int LFT_SH = (OUT_BITS > 31) ? OUT_BITS - 31 : 0;
    localparam logic [39:0] RND_ADD    = (40'd1 << RND_SH) >> 1;
    localparam logic [39:0] OUT_MAG_HI = (40'd1 << (OUT_BITS - 1)) - 40'd1;
    localparam logic [39:0] OUT_MAG_LO = 40'd1 << (OUT_BITS - 1);

    // One Horner step: c - (p * u >> 30), floored at zero
    function automatic coef_t horner_step(coef_t c, coef_t p, usq_t u);
        logic [61:0] prod;
        coef_t       t;
        prod = p * u;
        t = 33'(prod[61:30]);
        return (t > c) ? '0 : c - t;
    endfunction

    // Q30 product on magnitudes, rounded half up, then signed
    function automatic q30_t mulq(q30_t a, q30_t b);
        logic        neg;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] prod;
        logic [63:0] rnd;
        q30_t        mq;
        neg  = a[32] ^ b[32];
        ma   = a[32] ? 32'(-a) : 32'(a);
        mb   = b[32] ? 32'(-b) : 32'(b);
        prod = ma * mb;
        rnd  = prod + 64'd536870912;
        mq   = q30_t'(rnd[62:30]);
        return neg ? -mq : mq;
    endfunction

    // Q30 to saturated Q1.(OUT_BITS-1)
    function automatic qout_t to_out(qsum_t v);
        logic                neg;
        logic [39:0]         m;
        logic [39:0]         ms;
        logic [39:0]         nm;
        logic [OUT_BITS-1:0] r;
        neg = v[34];
        m   = neg ? 40'(-v) : 40'(v);
        ms  = ((m + RND_ADD) >> RND_SH) << LFT_SH;
        nm  = 40'd0 - ms;
        if (!neg)
        begin
            r = (ms > OUT_MAG_HI) ? OUT_MAG_HI[OUT_BITS-1:0] : ms[OUT_BITS-1:0];
        end
        else
        begin
            r = (ms > OUT_MAG_LO) ? OUT_MAG_LO[OUT_BITS-1:0] : nm[OUT_BITS-1:0];
        end
        return qout_t'(r);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ezq_sincos.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ezq_sincos (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire ezq_pkg::angle_t angle,
    output ezq_pkg::q30_t        sin_q,
    output ezq_pkg::q30_t        cos_q
);
    import ezq_pkg::*;

    localparam int SH_L = (ANGLE_BITS <= 30) ? 30 - ANGLE_BITS : 0;
    localparam int SH_R = (ANGLE_BITS > 30) ? ANGLE_BITS - 30 : 0;

    logic                  neg;
    logic [ANGLE_BITS-1:0] mag;
    logic [63:0]           mag_wide;
    xq_t                   xq;
    logic [59:0]           xq_sq;
    usq_t                  u;

    xq_t   xq_reg  [0:5];
    usq_t  u_reg   [0:5];
    logic  neg_reg [0:5];
    coef_t sp_reg  [1:5];
    coef_t cp_reg  [1:5];
    q30_t  sin_reg;
    q30_t  cos_reg;

    logic [62:0] sin_prod;
    logic [32:0] sin_mag;
    q30_t        sin_next;
    logic [61:0] cos_prod;
    coef_t       cos_t;
    q30_t        cos_next;

    // Half angle magnitude in Q30 and its square
    always_comb
    begin
        neg      = angle[ANGLE_BITS-1];
        mag      = neg ? ANGLE_BITS'(-angle) : ANGLE_BITS'(angle);
        mag_wide = (64'(mag) << SH_L) >> SH_R;
        xq       = mag_wide[29:0];
        xq_sq    = 60'(xq) * 60'(xq);
        u        = xq_sq[58:30];
    end

    // Final multiply of both polynomials
    always_comb
    begin
        sin_prod = sp_reg[5] * xq_reg[5];
        sin_mag  = sin_prod[62:30];
        sin_next = neg_reg[5] ? -q30_t'(sin_mag) : q30_t'(sin_mag);
        cos_prod = cp_reg[5] * u_reg[5];
        cos_t    = 33'(cos_prod[61:30]);
        cos_next = (cos_t > Q30_ONE) ? '0 : q30_t'(Q30_ONE - cos_t);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xq_reg[0]  <= xq;
            u_reg[0]   <= u;
            neg_reg[0] <= neg;
            for (int k = 1; k <= 5; k++)
            begin
                xq_reg[k]  <= xq_reg[k-1];
                u_reg[k]   <= u_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
            sp_reg[1] <= horner_step(SIN_COEF[1], SIN_COEF[0], u_reg[0]);
            cp_reg[1] <= horner_step(COS_COEF[1], COS_COEF[0], u_reg[0]);
            for (int k = 2; k <= 5; k++)
            begin
                sp_reg[k] <= horner_step(SIN_COEF[k], sp_reg[k-1], u_reg[k-1]);
                cp_reg[k] <= horner_step(COS_COEF[k], cp_reg[k-1], u_reg[k-1]);
            end
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/euler_zyx_to_quaternion.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Z-Y-X Euler angles to unit quaternion, ten register stages deep.
// Throughput: one item per cycle when not stalled; each multiply of the sine/cosine polynomials,
// the pair products and the triple products has a stage of its own.
// Reset (rst_n low, asynchronous) empties the pipeline; data registers are not cleared.

module euler_zyx_to_quaternion (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             angle_valid,
    output logic                  angle_stall,
    input  wire ezq_pkg::angles_t angle,
    output logic                  quat_valid,
    input  wire logic             quat_stall,
    output ezq_pkg::quat_t        quat
);
    import ezq_pkg::*;

    localparam int DEPTH = 10;

    logic             en;
    logic [DEPTH-1:0] valid_reg;

    q30_t sy;
    q30_t cy;
    q30_t sp;
    q30_t cp;
    q30_t sr;
    q30_t cr;

    // pair products
    q30_t cycp_reg;
    q30_t sysp_reg;
    q30_t cysp_reg;
    q30_t sycp_reg;
    q30_t sr_reg;
    q30_t cr_reg;

    // triple products, two per component
    q30_t w_a_reg;
    q30_t w_b_reg;
    q30_t x_a_reg;
    q30_t x_b_reg;
    q30_t y_a_reg;
    q30_t y_b_reg;
    q30_t z_a_reg;
    q30_t z_b_reg;

    quat_t quat_reg;
    quat_t quat_next;

    // The whole pipeline moves together; it holds only when the result
    // in the output register is not taken.
    assign en          = !(valid_reg[DEPTH-1] && quat_stall);
    assign angle_stall = !en;

    // Sine and cosine of each half angle: stages 0 to 6
    ezq_sincos u_yaw (
        .clk   (clk),
        .en    (en),
        .angle (angle.yaw_angle),
        .sin_q (sy),
        .cos_q (cy)
    );

    ezq_sincos u_pitch (
        .clk   (clk),
        .en    (en),
        .angle (angle.pitch_angle),
        .sin_q (sp),
        .cos_q (cp)
    );

    ezq_sincos u_roll (
        .clk   (clk),
        .en    (en),
        .angle (angle.roll_angle),
        .sin_q (sr),
        .cos_q (cr)
    );

    // Combine each pair of products and scale to the output format
    always_comb
    begin
        quat_next.quat_w = to_out(qsum_t'(w_a_reg) + qsum_t'(w_b_reg));
        quat_next.quat_x = to_out(qsum_t'(x_a_reg) - qsum_t'(x_b_reg));
        quat_next.quat_y = to_out(qsum_t'(y_a_reg) + qsum_t'(y_b_reg));
        quat_next.quat_z = to_out(qsum_t'(z_a_reg) - qsum_t'(z_b_reg));
    end

    // Valid bits advance with the data; a bubble is just a zero bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], angle_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 7: yaw and pitch pairs, delay roll alongside
            cycp_reg <= mulq(cy, cp);
            sysp_reg <= mulq(sy, sp);
            cysp_reg <= mulq(cy, sp);
            sycp_reg <= mulq(sy, cp);
            sr_reg   <= sr;
            cr_reg   <= cr;
            // stage 8: fold in roll
            w_a_reg  <= mulq(cycp_reg, cr_reg);
            w_b_reg  <= mulq(sysp_reg, sr_reg);
            x_a_reg  <= mulq(cycp_reg, sr_reg);
            x_b_reg  <= mulq(sysp_reg, cr_reg);
            y_a_reg  <= mulq(cysp_reg, cr_reg);
            y_b_reg  <= mulq(sycp_reg, sr_reg);
            z_a_reg  <= mulq(sycp_reg, cr_reg);
            z_b_reg  <= mulq(cysp_reg, sr_reg);
            // stage 9: output register
            quat_reg <= quat_next;
        end
    end

    assign quat_valid = valid_reg[DEPTH-1];
    assign quat       = quat_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ezq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ezq_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             angle_stall,
    input wire logic             quat_valid,
    input wire logic             quat_stall,
    input wire ezq_pkg::quat_t   quat
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !quat_valid)
        else $error("result valid after a reset edge");

    // Input is held back only by a waiting, untaken result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall |-> (quat_valid && quat_stall))
        else $error("input stalled without a blocked result");

    // Blocked result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (quat_valid && quat_stall) |=> (quat_valid && $stable(quat)))
        else $error("result changed while stalled");

endmodule

bind euler_zyx_to_quaternion ezq_checker u_ezq_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Cover the zero attitude, each angle at its extremes and quarter turns, and
    // bit patterns first. Then run four idle/stall phases of random attitudes.
    localparam int NUM_DIRECTED     = 21;
    localparam int NUM_PHASES       = 4;
    localparam int RANDOM_PER_PHASE = 332;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_LIMIT      = 50000;
    localparam int LATENCY_GUARD    = 20;
    localparam int MAX_REPORTS      = 100;

    // Percent of cycles in which the sender idles or the receiver stalls.
    localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 51, 0, 31};
    localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 51, 31};

    // Q30 polynomial coefficients, highest power first.
    localparam longint unsigned SINE_Q30 [6] = '{
        64'd7913939, 64'd88203478, 64'd643455390,
        64'd2738217788, 64'd5548789346, 64'd3373259426
    };
    localparam longint unsigned COSINE_Q30 [6] = '{
        64'd2071860, 64'd27709937, 64'd252684340,
        64'd1433727482, 64'd4358008966, 64'd5298703515
    };
    localparam longint Q30_UNIT = 64'sd1073741824;

    typedef struct {
        ezq_pkg::angles_t ang;
        bit               typed;  // expected result typed in below
        ezq_pkg::quat_t   want;
    } angle_row_t;

    // Rows with typed results: the zero attitude gives w = +1.0, saturated.
    angle_row_t directed_rows [NUM_DIRECTED] = '{
        '{{16'h0000, 16'h0000, 16'h0000}, 1'b1, {16'h7FFF, 16'h0000, 16'h0000, 16'h0000}},
        '{{16'h8000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{{16'h7FFF, 16'h0000, 16'h0000}, 1'b0, '0},
        '{{16'h0000, 16'h8000, 16'h0000}, 1'b0, '0},
        '{{16'h0000, 16'h7FFF, 16'h0000}, 1'b0, '0},
        '{{16'h0000, 16'h0000, 16'h8000}, 1'b0, '0},
        '{{16'h0000, 16'h0000, 16'h7FFF}, 1'b0, '0},
        '{{16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
        '{{16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '0},
        '{{16'h4000, 16'h0000, 16'h0000}, 1'b0, '0},
        '{{16'h0000, 16'hC000, 16'h0000}, 1'b0, '0},
        '{{16'h0000, 16'h0000, 16'h4000}, 1'b0, '0},
        '{{16'h0001, 16'hFFFF, 16'h0001}, 1'b0, '0},
        '{{16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '0},
        '{{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0},
        '{{16'h2000, 16'h4000, 16'hE000}, 1'b0, '0},
        '{{16'hC000, 16'hC000, 16'h4000}, 1'b0, '0},
        '{{16'h4000, 16'h4000, 16'h4000}, 1'b0, '0},
        '{{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{{16'h7FFF, 16'h8000, 16'h0000}, 1'b0, '0},
        '{{16'h0000, 16'h0000, 16'h0000}, 1'b1, {16'h7FFF, 16'h0000, 16'h0000, 16'h0000}}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   angle_valid;
    logic                   angle_stall;
    ezq_pkg::angles_t       angle;
    logic                   quat_valid;
    logic                   quat_stall;
    ezq_pkg::quat_t         quat;

    ezq_pkg::quat_t         expected_quats [$];
    int                     items_sent;
    int                     quats_checked;
    int                     mismatches;
    int                     send_idle_pct;
    int                     stall_pct;
    int                     hold_off_asked;

    euler_zyx_to_quaternion uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .angle       (angle),
        .quat_valid  (quat_valid),
        .quat_stall  (quat_stall),
        .quat        (quat)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Sine and cosine of half the binary angle, in Q30. The angle over 2^16 is
    // already the half angle as a fraction of pi, so scale it by 2^14 into Q30.
    function automatic void half_angle_sincos(input longint a, output longint s,
                                              output longint c);
        bit                neg;
        longint unsigned   mag;
        longint unsigned   xq;
        longint unsigned   u;
        longint unsigned   p;
        longint unsigned   t;
        longint            cv;
        neg = (a < 0);
        mag = neg ? longint'(-a) : longint'(a);
        xq  = mag << 14;
        u   = (xq * xq) >> 30;

        // Horner steps truncate and floor at zero.
        p = SINE_Q30[0];
        for (int i = 1; i < 6; i++)
        begin
            t = (p * u) >> 30;
            p = (t > SINE_Q30[i]) ? 64'd0 : SINE_Q30[i] - t;
        end
        p = (p * xq) >> 30;
        s = neg ? -longint'(p) : longint'(p);

        p = COSINE_Q30[0];
        for (int i = 1; i < 6; i++)
        begin
            t = (p * u) >> 30;
            p = (t > COSINE_Q30[i]) ? 64'd0 : COSINE_Q30[i] - t;
        end
        cv = Q30_UNIT - longint'((p * u) >> 30);
        c  = (cv < 0) ? 64'sd0 : cv;
    endfunction

    // Q30 product on magnitudes, rounded half up, then signed.
    function automatic longint q30_product(input longint a, input longint b);
        bit              neg;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? longint'(-a) : longint'(a);
        mb  = (b < 0) ? longint'(-b) : longint'(b);
        m   = (ma * mb + 64'd536870912) >> 30;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Q30 to saturated Q1.15, rounding the magnitude half up.
    function automatic ezq_pkg::qout_t q15_from_q30(input longint v);
        bit              neg;
        longint unsigned m;
        longint          r;
        neg = (v < 0);
        m   = neg ? longint'(-v) : longint'(v);
        m   = (m + 64'd16384) >> 15;
        r   = neg ? -longint'(m) : longint'(m);
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    // Quaternion of Rz(yaw) * Ry(pitch) * Rx(roll).
    function automatic ezq_pkg::quat_t quat_from_angles(input ezq_pkg::angles_t a);
        longint         sy, cy, sp, cp, sr, cr;
        longint         cycp, sysp, cysp, sycp;
        ezq_pkg::quat_t q;
        half_angle_sincos(longint'(a.yaw_angle), sy, cy);
        half_angle_sincos(longint'(a.pitch_angle), sp, cp);
        half_angle_sincos(longint'(a.roll_angle), sr, cr);
        cycp = q30_product(cy, cp);
        sysp = q30_product(sy, sp);
        cysp = q30_product(cy, sp);
        sycp = q30_product(sy, cp);
        q.quat_w = q15_from_q30(q30_product(cycp, cr) + q30_product(sysp, sr));
        q.quat_x = q15_from_q30(q30_product(cycp, sr) - q30_product(sysp, cr));
        q.quat_y = q15_from_q30(q30_product(cysp, cr) + q30_product(sycp, sr));
        q.quat_z = q15_from_q30(q30_product(sycp, cr) - q30_product(cysp, sr));
        return q;
    endfunction

    // Favor the corners of the angle range, otherwise draw from the whole circle.
    function automatic ezq_pkg::angle_t random_angle();
        if ($urandom_range(9) < 3)
        begin
            case ($urandom_range(9))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                3: return 16'h4000;
                4: return 16'hC000;
                5: return 16'h0001;
                6: return 16'hFFFF;
                7: return 16'h8001;
                8: return 16'h3FFF;
                default: return 16'hC001;
            endcase
        end
        return 16'($urandom_range(65535));
    endfunction

    // Offer one item after any idle cycles, hold it until taken, then log the
    // quaternion that it must produce.
    task automatic offer_angles(input ezq_pkg::angles_t a, input bit typed,
                                input ezq_pkg::quat_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            angle_valid <= 1'b0;
            @(posedge clk);
        end
        angle_valid <= 1'b1;
        angle       <= a;
        @(posedge clk);
        while (angle_stall)
        begin
            @(posedge clk);
        end
        expected_quats.push_back(typed ? want : quat_from_angles(a));
        items_sent++;
    endtask

    task automatic report_field(input string name, input ezq_pkg::qout_t want,
                                input ezq_pkg::qout_t got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("%0t ns: quat_%s mismatch, expected %0d, got %0d",
                         $time, name, want, got);
            end
        end
    endtask

    // Receiver: stall at the phase rate, or hold off for a long stretch when
    // asked, so that the pipeline fills and pushes back on the sender.
    initial
    begin : receiver
        int hold_left;
        int hold_off_served;
        hold_left       = 0;
        hold_off_served = 0;
        quat_stall      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_served != hold_off_asked)
            begin
                hold_off_served = hold_off_asked;
                hold_left       = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                quat_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                quat_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Check each quaternion taken against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        ezq_pkg::quat_t want;
        if (rst_n && quat_valid && !quat_stall)
        begin
            if (expected_quats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("%0t ns: unexpected quaternion, expected none, got %h",
                             $time, quat);
                end
            end
            else
            begin
                want = expected_quats.pop_front();
                quats_checked++;
                report_field("w", want.quat_w, quat.quat_w);
                report_field("x", want.quat_x, quat.quat_x);
                report_field("y", want.quat_y, quat.quat_y);
                report_field("z", want.quat_z, quat.quat_z);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int drain;
        rst_n          = 1'b0;
        angle_valid    = 1'b0;
        angle          = '0;
        items_sent     = 0;
        quats_checked  = 0;
        mismatches     = 0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_off_asked = 0;

        // Hold reset, then release it at an edge.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows with no idling.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            offer_angles(directed_rows[i].ang, directed_rows[i].typed,
                         directed_rows[i].want);
        end

        // Random attitudes in each idle/stall phase. Early in the first phase, hold
        // off the receiver while the sender keeps offering items.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle_pct = SEND_IDLE_PCT[ph];
            stall_pct     = RECV_STALL_PCT[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (ph == 0 && n == 40)
                begin
                    hold_off_asked++;
                end
                offer_angles({random_angle(), random_angle(), random_angle()}, 1'b0, '0);
            end
        end

        // Drop valid and drain the pipeline.
        angle_valid <= 1'b0;
        drain = 0;
        while (expected_quats.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (expected_quats.size() != 0)
        begin
            $display("%0t ns: %0d quaternions never arrived", $time, expected_quats.size());
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            repeat (LATENCY_GUARD) @(posedge clk);
            $display("Covered %0d attitudes (%0d directed), %0d quaternions checked,",
                     items_sent, NUM_DIRECTED, quats_checked);
            $display("under four idle/stall mixes and one long output hold-off; %0d mismatches",
                     mismatches);
            if (mismatches == 0)
            begin
                $display("Test completed successfully");
            end
            else
            begin
                $display("Test completed with failures");
            end
            $finish;
        end
    end

endmodule
